// ===== rtl/cvsq_pkg.sv =====
// Shared types and constants for the convex vertex set query unit.
package cvsq_pkg;

   localparam int COORD_W  = 32;
   localparam int OPND_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * OPND_W;
   localparam int METRIC_W = PROD_W + 1;
   localparam int OP_W     = 3;

   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
   localparam logic [OP_W-1:0] OP_SUPPORT = 3'd2;
   localparam logic [OP_W-1:0] OP_CLOSEST = 3'd3;
   localparam logic [OP_W-1:0] OP_BOUNDS  = 3'd4;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [OPND_W-1:0]   opnd_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [METRIC_W-1:0] metric_type;

   // Packed so that x sits in the lowest bits.
   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } vec_type;

   // Sideband that travels with each vertex through the scan pipeline.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

endpackage

// ===== rtl/cvsq_metric.sv =====
// Three-stage metric pipeline: dot product or squared distance of one vertex.
module cvsq_metric
   import cvsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       closest,
   input  vec_type    query,
   input  tag_type    in_tag,
   input  vec_type    in_vertex,
   output tag_type    out_tag,
   output vec_type    out_vertex,
   output metric_type out_metric
);

   coord_type  vert_ax[3];
   coord_type  query_ax[3];
   opnd_type   opa_in[3];
   opnd_type   opb_in[3];
   opnd_type   opa_ff[3];
   opnd_type   opb_ff[3];
   prod_type   prod_ff[3];
   metric_type sum_ff;
   tag_type    tag1_ff, tag2_ff, tag3_ff;
   vec_type    vert1_ff, vert2_ff, vert3_ff;

   assign vert_ax[0]  = in_vertex.x;
   assign vert_ax[1]  = in_vertex.y;
   assign vert_ax[2]  = in_vertex.z;
   assign query_ax[0] = query.x;
   assign query_ax[1] = query.y;
   assign query_ax[2] = query.z;

   // Stage one operands: the raw coordinates for a dot product, or the
   // magnitude of the per-axis difference (always below 2^32) for a distance.
   always_comb begin
      opnd_type sv;
      opnd_type sq;
      opnd_type diff;
      opnd_type mag;
      for (int a = 0; a < 3; a++) begin
         sv   = OPND_W'(vert_ax[a]);
         sq   = OPND_W'(query_ax[a]);
         diff = sv - sq;
         mag  = diff[OPND_W-1] ? -diff : diff;
         opa_in[a] = closest ? mag : sv;
         opb_in[a] = closest ? mag : sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         opa_ff[a]  <= opa_in[a];
         opb_ff[a]  <= opb_in[a];
         prod_ff[a] <= opa_ff[a] * opb_ff[a];
      end
      sum_ff   <= METRIC_W'(prod_ff[0]) + METRIC_W'(prod_ff[1]) + METRIC_W'(prod_ff[2]);
      vert1_ff <= in_vertex;
      vert2_ff <= vert1_ff;
      vert3_ff <= vert2_ff;
   end

   assign out_tag    = tag3_ff;
   assign out_vertex = vert3_ff;
   assign out_metric = sum_ff;

endmodule

// ===== rtl/convex_vertex_set_query_unit.sv =====
// Top level of the convex vertex set query unit: vertex store, scan control, result register.
// Clear and append complete on acceptance and leave the unit ready for the next request. A
// query on a nonempty store raises rsp_tvalid once its scan is done (a bounds query gives its
// second result after the first) and takes the next request once its last result is loaded;
// an empty store answers without a scan. The single memory read port sets one vertex a cycle.
// Synchronous active-high reset empties the store and control state; memory is not cleared.
module convex_vertex_set_query_unit
   import cvsq_pkg::*;
#(
   parameter int MAX_VERTICES = 64
)
(
   input  logic            clock,
   input  logic            reset,
   // Request channel.
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [95:0]     req_tdata,   // coord_x [31:0], coord_y [63:32], coord_z [95:64]
   input  logic [OP_W-1:0] req_tuser,   // op [2:0]
   // Result channel.
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [95:0]     rsp_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
   output logic            rsp_tuser,   // store_empty [0]
   output logic            rsp_tlast
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // Vertex store. Writes happen only while idle and reads only while scanning, so the
   // state machine keeps the two from ever touching the same entry in the same cycle.
   vec_type mem [MAX_VERTICES];

   logic [1:0]      state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic            issuing_ff, issuing_in;
   logic            empty_ff, empty_in;
   logic            phase_ff, phase_in;
   logic [OP_W-1:0] op_ff, op_in;
   vec_type         query_ff, query_in;

   logic            req_accept;
   logic            wr_en;
   logic            rd_en;
   tag_type         rd_tag_in;
   tag_type         rd_tag_ff;
   vec_type         rd_q_ff;

   tag_type         m_tag;
   vec_type         m_vertex;
   metric_type      m_metric;

   metric_type      best_metric_ff;
   vec_type         best_vert_ff;
   vec_type         min_ff;
   vec_type         max_ff;
   logic            better;

   logic            rsp_valid_ff, rsp_valid_in;
   vec_type         rsp_data_ff, rsp_data_in;
   logic            rsp_empty_ff, rsp_empty_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            slot_free;
   logic            load;
   logic            load_last;
   vec_type         load_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign wr_en      = req_accept && (req_tuser == OP_APPEND) && (count_ff < CW'(MAX_VERTICES));
   assign rd_en      = (state_ff == ST_SCAN) && issuing_ff;

   // Tag for the read being issued this cycle.
   always_comb begin
      rd_tag_in.valid = rd_en;
      rd_tag_in.first = (idx_ff == '0);
      rd_tag_in.last  = (CW'(idx_ff) == CW'(count_ff - CW'(1)));
   end

   // Control state machine.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      issuing_in = issuing_ff;
      empty_in   = empty_ff;
      phase_in   = phase_ff;
      op_in      = op_ff;
      query_in   = query_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_tuser) inside
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (wr_en) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_SUPPORT, OP_CLOSEST, OP_BOUNDS: begin
                     op_in    = req_tuser;
                     query_in = vec_type'(req_tdata);
                     phase_in = 1'b0;
                     idx_in   = '0;
                     if (count_ff == '0) begin
                        empty_in = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        empty_in   = 1'b0;
                        issuing_in = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
                  default: begin
                     // Unused codes are dropped without effect.
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               idx_in = idx_ff + AW'(1);
               if (rd_tag_in.last) begin
                  issuing_in = 1'b0;
               end
            end
            // The last vertex enters the compare stage when its tag shows up here.
            if (m_tag.valid && m_tag.last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               if (load_last) begin
                  state_in = ST_IDLE;
                  phase_in = 1'b0;
               end else begin
                  phase_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         idx_ff     <= '0;
         issuing_ff <= 1'b0;
         empty_ff   <= 1'b0;
         phase_ff   <= 1'b0;
         rd_tag_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         issuing_ff <= issuing_in;
         empty_ff   <= empty_in;
         phase_ff   <= phase_in;
         rd_tag_ff  <= rd_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      query_ff <= query_in;
   end

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= vec_type'(req_tdata);
      end
      if (rd_en) begin
         rd_q_ff <= mem[idx_ff];
      end
   end

   cvsq_metric u_metric (
      .clock      (clock),
      .reset      (reset),
      .closest    (op_ff == OP_CLOSEST),
      .query      (query_ff),
      .in_tag     (rd_tag_ff),
      .in_vertex  (rd_q_ff),
      .out_tag    (m_tag),
      .out_vertex (m_vertex),
      .out_metric (m_metric)
   );

   // Compare stage. Only a strictly better metric replaces the winner, so ties keep the
   // earliest vertex. Bounds are tracked on every scan and used only by a bounds query.
   assign better = (op_ff == OP_CLOSEST) ? (m_metric < best_metric_ff)
                                         : (m_metric > best_metric_ff);

   always_ff @(posedge clock) begin
      if (m_tag.valid) begin
         if (m_tag.first) begin
            best_metric_ff <= m_metric;
            best_vert_ff   <= m_vertex;
            min_ff         <= m_vertex;
            max_ff         <= m_vertex;
         end else begin
            if (better) begin
               best_metric_ff <= m_metric;
               best_vert_ff   <= m_vertex;
            end
            if (m_vertex.x < min_ff.x) min_ff.x <= m_vertex.x;
            if (m_vertex.y < min_ff.y) min_ff.y <= m_vertex.y;
            if (m_vertex.z < min_ff.z) min_ff.z <= m_vertex.z;
            if (m_vertex.x > max_ff.x) max_ff.x <= m_vertex.x;
            if (m_vertex.y > max_ff.y) max_ff.y <= m_vertex.y;
            if (m_vertex.z > max_ff.z) max_ff.z <= m_vertex.z;
         end
      end
   end

   // Result register. A new result loads when the register is empty or being drained,
   // which lets the next request be taken while the final result still waits.
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign load      = (state_ff == ST_EMIT) && slot_free;

   always_comb begin
      if (empty_ff) begin
         load_data = '0;
         load_last = (op_ff != OP_BOUNDS) || phase_ff;
      end else if (op_ff == OP_BOUNDS) begin
         load_data = phase_ff ? max_ff : min_ff;
         load_last = phase_ff;
      end else begin
         load_data = best_vert_ff;
         load_last = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_data;
         rsp_empty_in = empty_ff;
         rsp_last_in  = load_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
